// ===== src/cbts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the microcode table of the Bezier t solver.
package cbts_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int MAX_STEPS_DEF     = 32;

	localparam int COORD_W     = 32;
	localparam int IN_DATA_W   = 5 * COORD_W;
	localparam int T_OUT_W     = 17;
	localparam int STEPS_OUT_W = 6;
	localparam int OUT_DATA_W  = 24;

	localparam int TOL_W       = 16;
	localparam int LIMIT_W     = 6;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ITER_LIMIT = 2'd1;

	localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd24;

	localparam int UC_PC_W = 4;

	typedef enum logic [2:0] {MA_U, MA_T, MA_U2, MA_T2, MA_WA, MA_WB} mul_a_t;
	typedef enum logic [2:0] {MB_U, MB_T, MB_T2, MB_P0, MB_P1, MB_P2, MB_P3} mul_b_t;
	typedef enum logic [2:0] {WB_NONE, WB_U2, WB_T2, WB_WA, WB_WA3, WB_WB, WB_WB3} wb_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_t;
	typedef enum logic [1:0] {SQ_NEXT, SQ_ROUND, SQ_DIFF, SQ_TEST} sq_t;

	typedef struct packed {
		mul_a_t mul_a;
		mul_b_t mul_b;
		wb_t    wb;
		acc_t   acc;
		sq_t    sq;
	} uc_word_t;

	typedef struct packed {
		logic     load;
		logic     bisect;
		uc_word_t uc;
	} dp_ctrl_t;

	typedef struct packed {
		logic in_tol;
		logic above;
	} dp_stat_t;

	localparam uc_word_t UC_IDLE = '{MA_U, MB_U, WB_NONE, ACC_HOLD, SQ_NEXT};

	// One curve evaluation: weights on the shared multiplier, then the
	// weighted sum, rounding, error and the branch step.
	function automatic uc_word_t uc_rom(input logic [UC_PC_W-1:0] pc);
		uc_word_t w;
		w = UC_IDLE;
		unique case (pc)
			4'd0:  w = '{MA_U,  MB_U,  WB_NONE, ACC_HOLD, SQ_NEXT};
			4'd1:  w = '{MA_T,  MB_T,  WB_U2,   ACC_HOLD, SQ_NEXT};
			4'd2:  w = '{MA_U2, MB_U,  WB_T2,   ACC_HOLD, SQ_NEXT};
			4'd3:  w = '{MA_U2, MB_T,  WB_WA,   ACC_HOLD, SQ_NEXT};
			4'd4:  w = '{MA_WA, MB_P0, WB_WB3,  ACC_HOLD, SQ_NEXT};
			4'd5:  w = '{MA_WB, MB_P1, WB_NONE, ACC_LOAD, SQ_NEXT};
			4'd6:  w = '{MA_U,  MB_T2, WB_NONE, ACC_ADD,  SQ_NEXT};
			4'd7:  w = '{MA_T2, MB_T,  WB_WA3,  ACC_HOLD, SQ_NEXT};
			4'd8:  w = '{MA_WA, MB_P2, WB_WB,   ACC_HOLD, SQ_NEXT};
			4'd9:  w = '{MA_WB, MB_P3, WB_NONE, ACC_ADD,  SQ_NEXT};
			4'd10: w = '{MA_U,  MB_U,  WB_NONE, ACC_ADD,  SQ_NEXT};
			4'd11: w = '{MA_U,  MB_U,  WB_NONE, ACC_HOLD, SQ_ROUND};
			4'd12: w = '{MA_U,  MB_U,  WB_NONE, ACC_HOLD, SQ_DIFF};
			4'd13: w = '{MA_U,  MB_U,  WB_NONE, ACC_HOLD, SQ_TEST};
			default: w = UC_IDLE;
		endcase
		return w;
	endfunction

endpackage

// ===== src/cubic_bezier_t_solver.sv =====
`timescale 1ns / 1ps
// Cubic Bezier inverse: bisection search for t with a microcoded datapath.
//
// Requests arrive on s_tvalid/s_tready/s_tdata: target value and four
// control values, signed Q16.16. One result per request leaves on
// m_tvalid/m_tready/m_tdata with the converged flag on m_tuser.
// Tolerance and iteration limit are written on cfg_valid/cfg_index/cfg_data,
// which is always ready; write them only while no request is in flight.
//
// One request is in work at a time. Each curve evaluation is one pass of a
// 14-step microprogram over a single shared multiplier, the last step of the
// final pass loading the output register.
// s_tready rises again as soon as the result is in the output register, so a
// new request is taken while the previous result waits. If the receiver still
// stalls when the next search ends, the sequencer holds on its branch step.
// Reset clears the handshake state and loads tolerance 7 and limit 24.
module cubic_bezier_t_solver import cbts_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int MAX_STEPS     = MAX_STEPS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// target_value, point_start, point_first_handle, point_second_handle, point_end
	input  logic [IN_DATA_W-1:0]   s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// parameter_t [16:0], steps_taken [22:17], zero pad [23]
	output logic [OUT_DATA_W-1:0]  m_tdata,
	// converged
	output logic                   m_tuser,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [TOL_W-1:0]   tol_q;
	logic [LIMIT_W-1:0] limit_q;

	logic                   out_valid_q;
	logic [T_OUT_W-1:0]     out_t_q;
	logic [STEPS_OUT_W-1:0] out_steps_q;
	logic                   out_conv_q;

	dp_ctrl_t               ctrl;
	dp_stat_t               stat;
	logic [FRACTION_BITS:0] t_value;
	logic                   busy, finish, converged, accept;
	logic [STEPS_OUT_W-1:0] steps;

	assign cfg_ready = 1'b1;
	assign s_tready  = !busy;
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= TOL_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TOLERANCE:  tol_q   <= cfg_data[TOL_W-1:0];
				REG_ITER_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				default:        ;
			endcase
		end
	end

	cbts_sequencer #(
		.MAX_STEPS(MAX_STEPS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.out_free  (!out_valid_q || m_tready),
		.cfg_limit (limit_q),
		.stat      (stat),
		.ctrl      (ctrl),
		.busy      (busy),
		.finish    (finish),
		.converged (converged),
		.steps     (steps)
	);

	cbts_datapath #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk       (clk),
		.in_data   (s_tdata),
		.tolerance (tol_q),
		.ctrl      (ctrl),
		.stat      (stat),
		.t_value   (t_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_t_q     <= T_OUT_W'(t_value);
			out_steps_q <= steps;
			out_conv_q  <= converged;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_steps_q, out_t_q};
	assign m_tuser  = out_conv_q;

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("request accepted while a search was running");

	a_finish_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> (!m_tvalid || m_tready))
		else $error("result overwrote one not yet taken");

	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (m_tvalid && s_tready))
		else $error("finished search did not present a result");
`endif

endmodule

// ===== src/cbts_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the Bezier t solver: shared multiplier, accumulator, bounds.
module cbts_datapath import cbts_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                      clk,
	input  logic [IN_DATA_W-1:0]      in_data,
	input  logic [TOL_W-1:0]          tolerance,
	input  dp_ctrl_t                  ctrl,
	output dp_stat_t                  stat,
	output logic [FRACTION_BITS:0]    t_value
);

	localparam int F    = FRACTION_BITS;
	localparam int TW   = F + 1;
	localparam int AW   = F + 2;
	localparam int BW   = COORD_W + 1;
	localparam int PW   = AW + 1 + BW;
	localparam int ACCW = PW + 2;
	localparam int XW   = ACCW - F;
	localparam int DW   = XW + 1;

	localparam logic [TW-1:0]          ONE_T  = TW'(1) << F;
	localparam logic [TW-1:0]          HALF_T = ONE_T >> 1;
	localparam logic [PW-1:0]          HALF_P = PW'(1) << (F - 1);
	localparam logic signed [ACCW-1:0] HALF_A = ACCW'(1) << (F - 1);

	logic signed [COORD_W-1:0] tgt_q;
	logic signed [COORD_W-1:0] pt_q [4];
	logic [TW-1:0]             t_q, lo_q, hi_q, u2_q, t2_q;
	logic [AW-1:0]             wa_q, wb_q;
	logic signed [PW-1:0]      prod_q;
	logic signed [ACCW-1:0]    acc_q;
	logic signed [XW-1:0]      x_q;
	logic signed [DW-1:0]      diff_q;

	logic [TW-1:0]          u_w;
	logic [AW-1:0]          mul_a;
	logic signed [BW-1:0]   mul_b;
	logic signed [PW-1:0]   prod_w;
	logic [PW-1:0]          rnd_sum;
	logic [TW-1:0]          rnd;
	logic [AW-1:0]          rnd3;
	logic signed [ACCW-1:0] xs;
	logic [DW-1:0]          mag;
	logic [TW:0]            mid_sum;

	assign u_w = ONE_T - t_q;

	always_comb begin
		case (ctrl.uc.mul_a)
			MA_U:    mul_a = AW'(u_w);
			MA_T:    mul_a = AW'(t_q);
			MA_U2:   mul_a = AW'(u2_q);
			MA_T2:   mul_a = AW'(t2_q);
			MA_WA:   mul_a = wa_q;
			MA_WB:   mul_a = wb_q;
			default: mul_a = '0;
		endcase
		case (ctrl.uc.mul_b)
			MB_U:    mul_b = BW'(u_w);
			MB_T:    mul_b = BW'(t_q);
			MB_T2:   mul_b = BW'(t2_q);
			MB_P0:   mul_b = BW'(pt_q[0]);
			MB_P1:   mul_b = BW'(pt_q[1]);
			MB_P2:   mul_b = BW'(pt_q[2]);
			MB_P3:   mul_b = BW'(pt_q[3]);
			default: mul_b = '0;
		endcase
	end

	assign prod_w  = $signed({1'b0, mul_a}) * mul_b;
	// weight products are never negative: round half up to Q1.F
	assign rnd_sum = prod_q + HALF_P;
	assign rnd     = rnd_sum[F +: TW];
	assign rnd3    = AW'(rnd) + (AW'(rnd) << 1);
	assign xs      = acc_q + HALF_A;

	assign mag         = diff_q[DW-1] ? DW'(-diff_q) : DW'(diff_q);
	assign stat.in_tol = (mag <= DW'(tolerance));
	assign stat.above  = !diff_q[DW-1] && (diff_q != '0);

	assign mid_sum = stat.above ? ((TW+1)'(t_q) + (TW+1)'(hi_q))
	                            : ((TW+1)'(lo_q) + (TW+1)'(t_q));
	assign t_value = t_q;

	always_ff @(posedge clk) begin
		prod_q <= prod_w;

		case (ctrl.uc.wb)
			WB_U2:   u2_q <= rnd;
			WB_T2:   t2_q <= rnd;
			WB_WA:   wa_q <= AW'(rnd);
			WB_WA3:  wa_q <= rnd3;
			WB_WB:   wb_q <= AW'(rnd);
			WB_WB3:  wb_q <= rnd3;
			default: ;
		endcase

		case (ctrl.uc.acc)
			ACC_LOAD: acc_q <= ACCW'(prod_q);
			ACC_ADD:  acc_q <= acc_q + ACCW'(prod_q);
			default:  ;
		endcase

		case (ctrl.uc.sq)
			SQ_ROUND: x_q    <= xs[ACCW-1:F];
			SQ_DIFF:  diff_q <= DW'(tgt_q) - DW'(x_q);
			default:  ;
		endcase

		if (ctrl.load) begin
			tgt_q   <= in_data[0*COORD_W +: COORD_W];
			pt_q[0] <= in_data[1*COORD_W +: COORD_W];
			pt_q[1] <= in_data[2*COORD_W +: COORD_W];
			pt_q[2] <= in_data[3*COORD_W +: COORD_W];
			pt_q[3] <= in_data[4*COORD_W +: COORD_W];
			t_q     <= HALF_T;
			lo_q    <= '0;
			hi_q    <= ONE_T;
		end else if (ctrl.bisect) begin
			if (stat.above) begin
				lo_q <= t_q;
			end else begin
				hi_q <= t_q;
			end
			t_q <= mid_sum[TW:1];
		end
	end

endmodule

// ===== src/cbts_sequencer.sv =====
`timescale 1ns / 1ps
// Microcode sequencer of the Bezier t solver: step counter, branch, step count.
module cbts_sequencer import cbts_pkg::*; #(
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic                   out_free,
	input  logic [LIMIT_W-1:0]     cfg_limit,
	input  dp_stat_t               stat,
	output dp_ctrl_t               ctrl,
	output logic                   busy,
	output logic                   finish,
	output logic                   converged,
	output logic [STEPS_OUT_W-1:0] steps
);

	localparam int SW = $clog2(MAX_STEPS + 1);
	localparam int LW = (SW > LIMIT_W) ? SW : LIMIT_W;

	logic               busy_q;
	logic [UC_PC_W-1:0] pc_q;
	logic [SW-1:0]      steps_q;

	logic [SW-1:0] limit_eff;
	logic          test, at_limit, stop;

	assign limit_eff = (LW'(cfg_limit) > LW'(MAX_STEPS)) ? SW'(MAX_STEPS) : SW'(cfg_limit);

	assign ctrl.uc     = busy_q ? uc_rom(pc_q) : UC_IDLE;
	assign ctrl.load   = accept;
	assign test        = busy_q && (ctrl.uc.sq == SQ_TEST);
	assign at_limit    = (steps_q >= limit_eff);
	assign stop        = test && (stat.in_tol || at_limit);
	assign ctrl.bisect = test && !stat.in_tol && !at_limit;
	// hold on the branch step until the output register can take the result
	assign finish      = stop && out_free;
	assign converged   = stat.in_tol;
	assign steps       = STEPS_OUT_W'(steps_q);
	assign busy        = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pc_q    <= '0;
			steps_q <= '0;
		end else if (accept) begin
			busy_q  <= 1'b1;
			pc_q    <= '0;
			steps_q <= '0;
		end else if (busy_q) begin
			if (finish) begin
				busy_q <= 1'b0;
			end else if (ctrl.bisect) begin
				pc_q    <= '0;
				steps_q <= SW'(steps_q + 1'b1);
			end else if (!test) begin
				pc_q <= UC_PC_W'(pc_q + 1'b1);
			end
		end
	end

endmodule

// ===== tb/cubic_bezier_t_solver_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Bezier t solver: directed and random searches with a predictor.
module cubic_bezier_t_solver_tb;
	import cbts_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
	localparam longint Q_ONE       = longint'(1) << FRACTION_BITS_DEF;
	localparam longint Q_HALF      = longint'(1) << (FRACTION_BITS_DEF - 1);
	localparam int     SETTLE_TAIL = 600;

	typedef struct {
		logic signed [COORD_W-1:0] target;
		logic signed [COORD_W-1:0] p0;
		logic signed [COORD_W-1:0] p1;
		logic signed [COORD_W-1:0] p2;
		logic signed [COORD_W-1:0] p3;
	} bez_request_t;

	typedef struct {
		logic [T_OUT_W-1:0]     t;
		logic                   converged;
		logic [STEPS_OUT_W-1:0] steps;
	} t_solution_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   m_tuser;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	logic [TOL_W-1:0]   tolerance_now;
	logic [LIMIT_W-1:0] limit_now;

	t_solution_t pending_solutions[$];
	int          tx_idle_pct;
	int          rx_stall_pct;
	int          error_count;
	int          searches_checked;
	int          searches_converged;
	int          settings_used;

	cubic_bezier_t_solver DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// Product of two Q1.16 weights, rounded half up.
	function automatic longint qmul(input longint x, input longint y);
		return (x * y + Q_HALF) >>> FRACTION_BITS_DEF;
	endfunction

	function automatic longint bezier_at(input longint t, input bez_request_t r);
		longint u, u2, t2, w0, w1, w2, w3, sum;
		u   = Q_ONE - t;
		u2  = qmul(u, u);
		t2  = qmul(t, t);
		w0  = qmul(u2, u);
		w1  = 3 * qmul(u2, t);
		w2  = 3 * qmul(u, t2);
		w3  = qmul(t2, t);
		sum = w0 * longint'(r.p0) + w1 * longint'(r.p1) + w2 * longint'(r.p2)
			+ w3 * longint'(r.p3);
		// arithmetic shift of a signed value is a floor
		return (sum + Q_HALF) >>> FRACTION_BITS_DEF;
	endfunction

	function automatic t_solution_t solve_bisection(input bez_request_t r);
		t_solution_t res;
		longint      tgt, x, err, lo, hi, t;
		int          lim, steps;
		bit          done;
		tgt   = longint'(r.target);
		lo    = 0;
		hi    = Q_ONE;
		t     = Q_ONE >> 1;
		steps = 0;
		done  = 1'b0;
		lim   = int'(limit_now);
		if (lim > MAX_STEPS_DEF)
			lim = MAX_STEPS_DEF;
		x = bezier_at(t, r);
		forever begin
			err = tgt - x;
			if (err < 0)
				err = -err;
			if (err <= longint'(tolerance_now)) begin
				done = 1'b1;
				break;
			end
			if (steps >= lim)
				break;
			if (tgt > x)
				lo = t;
			else
				hi = t;
			t = (lo + hi) >> 1;
			x = bezier_at(t, r);
			steps++;
		end
		res.t         = t[T_OUT_W-1:0];
		res.converged = done;
		res.steps     = steps[STEPS_OUT_W-1:0];
		return res;
	endfunction

	function automatic bez_request_t pack_request(input longint target, input longint a,
			input longint b, input longint c, input longint d);
		bez_request_t r;
		r.target = target[COORD_W-1:0];
		r.p0     = a[COORD_W-1:0];
		r.p1     = b[COORD_W-1:0];
		r.p2     = c[COORD_W-1:0];
		r.p3     = d[COORD_W-1:0];
		return r;
	endfunction

	// Mostly monotone curves with the target inside their span; the rest is noise.
	function automatic bez_request_t make_request();
		int     kind, sh, ra, rb;
		longint a, b, lo, hi, span, h1, h2, tg, tmp;
		kind = $urandom_range(99);
		if (kind < 20)
			return pack_request($urandom, $urandom, $urandom, $urandom, $urandom);
		sh   = $urandom_range(31);
		ra   = $urandom;
		rb   = $urandom;
		a    = longint'(ra) >>> sh;
		b    = longint'(rb) >>> sh;
		lo   = (a < b) ? a : b;
		hi   = (a < b) ? b : a;
		span = hi - lo;
		h1   = lo + ((span * $urandom_range(1024)) >> 10);
		h2   = lo + ((span * $urandom_range(1024)) >> 10);
		if (h1 > h2) begin
			tmp = h1;
			h1  = h2;
			h2  = tmp;
		end
		tg = lo + ((span * $urandom_range(1024)) >> 10);
		if (kind < 30) begin
			ra = $urandom;
			tg = ra;
		end
		if (kind >= 30 && kind < 40)
			return pack_request(tg, hi, h2, h1, lo);
		return pack_request(tg, lo, h1, h2, hi);
	endfunction

	// Hold valid high across back-to-back requests; lower it only for a gap.
	task automatic send_request(input bez_request_t r);
		int gap;
		gap = 0;
		while (gap < 64 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (tx_idle_pct > 0 && $urandom_range(15) == 0)
			gap = $urandom_range(1, 120);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r.p3, r.p2, r.p1, r.p0, r.target};
		do
			@(posedge clk);
		while (!s_tready);
		pending_solutions.push_back(solve_bisection(r));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_solutions.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_TOLERANCE:  tolerance_now = data[TOL_W-1:0];
			REG_ITER_LIMIT: limit_now     = data[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	// Drain, then load both registers; upper data bits above the limit field are junk.
	task automatic apply_settings(input logic [TOL_W-1:0] tol, input logic [LIMIT_W-1:0] lim);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		wait_idle();
		write_reg(REG_TOLERANCE, tol);
		write_reg(REG_ITER_LIMIT, {junk[CFG_DATA_W-1:LIMIT_W], lim});
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic send_list(input bez_request_t list[$]);
		foreach (list[i])
			send_request(list[i]);
	endtask

	// Reset registers; extremes of every input field and an exact tie.
	task automatic test_field_extremes();
		bez_request_t list[$];
		longint mx, mn, v;
		mx = 64'sd2147483647;
		mn = -64'sd2147483648;
		v  = longint'(1000) << 16;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		list.push_back(pack_request(0, 0, 0, 0, 0));
		list.push_back(pack_request(mx, mx, mx, mx, mx));
		list.push_back(pack_request(mn, mn, mn, mn, mn));
		list.push_back(pack_request(mx, mn, mn, mn, mn));
		list.push_back(pack_request(mn, mx, mx, mx, mx));
		list.push_back(pack_request(0, mn, mn, mx, mx));
		list.push_back(pack_request(0, mx, mx, mn, mn));
		list.push_back(pack_request(0, mx, mn, mx, mn));
		list.push_back(pack_request(-1, -1, -1, -1, -1));
		list.push_back(pack_request(v, v, v, v, v));
		list.push_back(pack_request(v >>> 1, 0, 0, v, v));
		send_list(list);
	endtask

	// Limit of zero, limit above the cap, limit reached.
	task automatic test_limit_cases();
		bez_request_t list[$];
		list.push_back(pack_request(12345, 0, 0, 65536, 65536));
		list.push_back(pack_request(32768, 0, 0, 65536, 65536));
		apply_settings(16'd0, 6'd0);
		send_list(list);
		apply_settings(16'd0, 6'd63);
		send_list(list);
		apply_settings(16'd0, 6'd33);
		send_list(list);
		apply_settings(16'd0, 6'd1);
		send_list(list);
		apply_settings(16'd0, 6'd32);
		send_list(list);
	endtask

	// Widest tolerance, then writes to unused indexes that must leave both registers alone.
	task automatic test_tolerance_and_spare_regs();
		bez_request_t r;
		r = pack_request(40000, -65536, 0, 0, 65536);
		apply_settings(16'hFFFF, 6'd24);
		send_request(r);
		apply_settings(16'd0, 6'd5);
		write_reg(REG_SPARE_A, 16'hFFFF);
		write_reg(REG_SPARE_B, 16'h0000);
		write_reg(REG_SPARE_A, 16'h0000);
		write_reg(REG_SPARE_B, 16'hFFFF);
		cfg_valid <= 1'b0;
		send_request(r);
	endtask

	task automatic test_random_phase(input logic [TOL_W-1:0] tol, input logic [LIMIT_W-1:0] lim,
			input int tx_pct, input int rx_pct, input int count);
		apply_settings(tol, lim);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		repeat (count)
			send_request(make_request());
	endtask

	// Check each result against the oldest prediction and pick the next ready.
	always @(posedge clk) begin
		t_solution_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_solutions.size() == 0) begin
				$error("result with nothing pending: tdata=%h tuser=%b", m_tdata, m_tuser);
				error_count++;
			end else begin
				want = pending_solutions.pop_front();
				searches_checked++;
				if (want.converged)
					searches_converged++;
				if (m_tdata[T_OUT_W-1:0] !== want.t) begin
					$error("parameter_t expected %0d got %0d", want.t, m_tdata[T_OUT_W-1:0]);
					error_count++;
				end
				if (m_tdata[T_OUT_W+STEPS_OUT_W-1:T_OUT_W] !== want.steps) begin
					$error("steps_taken expected %0d got %0d", want.steps,
						m_tdata[T_OUT_W+STEPS_OUT_W-1:T_OUT_W]);
					error_count++;
				end
				if (m_tuser !== want.converged) begin
					$error("converged expected %0b got %0b", want.converged, m_tuser);
					error_count++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		s_tvalid           = 1'b0;
		s_tdata            = '0;
		m_tready           = 1'b0;
		cfg_valid          = 1'b0;
		cfg_index          = REG_TOLERANCE;
		cfg_data           = '0;
		tolerance_now      = TOL_RESET;
		limit_now          = LIMIT_RESET;
		tx_idle_pct        = 0;
		rx_stall_pct       = 0;
		error_count        = 0;
		searches_checked   = 0;
		searches_converged = 0;
		settings_used      = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_limit_cases();
		test_tolerance_and_spare_regs();
		test_random_phase(16'd7, 6'd24, 0, 0, 125);
		test_random_phase(16'd0, 6'd32, 80, 0, 110);
		test_random_phase(16'hFFFF, 6'd1, 0, 80, 125);
		test_random_phase(TOL_W'($urandom), LIMIT_W'($urandom_range(1, 32)), 19, 19, 125);
		test_random_phase(TOL_W'($urandom_range(15)), 6'd63, 80, 80, 60);
		test_random_phase(16'd3, 6'd0, 19, 19, 40);
		test_random_phase(TOL_W'($urandom_range(255)), LIMIT_W'($urandom_range(2, 20)),
			0, 0, 150);

		wait_idle();
		repeat (SETTLE_TAIL) @(posedge clk);

		$display("Checked %0d searches under %0d register settings, %0d of them converged.",
			searches_checked, settings_used, searches_converged);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== cubic_bezier_t_solver.f =====
src/cbts_pkg.sv
src/cbts_datapath.sv
src/cbts_sequencer.sv
src/cubic_bezier_t_solver.sv
tb/cubic_bezier_t_solver_tb.sv
